// ----- hdl/kps_pkg.sv -----
// Shared types, constants and helpers for the keypad scanner.
`timescale 1ns / 1ps

package kps_pkg;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_POLL = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCKOUT      = 2'd3;

  // Register reset values.
  localparam logic [3:0] SETTLE_RST       = 4'd1;
  localparam logic [7:0] DEBOUNCE_RST     = 8'd20;
  localparam logic [7:0] RELEASE_POLL_RST = 8'd10;
  localparam logic [9:0] LOCKOUT_RST      = 10'd200;

  // No row driven.
  localparam logic [3:0] ROWS_IDLE = 4'hF;
  // Saturation value of the lockout tick counter.
  localparam logic [9:0] COUNT_MAX = 10'd1023;

  typedef struct packed {
    logic [3:0] settle_ticks;
    logic [7:0] debounce_ticks;
    logic [7:0] release_poll_ticks;
    logic [9:0] lockout_ticks;
  } cfg_t;

  typedef struct packed {
    logic [3:0] row_drive;
    logic       key_valid;
    logic [3:0] key_index;
  } result_t;

  // Active-low drive pattern for one row.
  function automatic logic [3:0] row_pattern(input logic [1:0] row);
    logic [3:0] pat;
    pat      = ROWS_IDLE;
    pat[row] = 1'b0;
    return pat;
  endfunction

endpackage

// ----- hdl/matrix_keypad_scanner_core.sv -----
// Top level of the 4x4 matrix keypad scanner with debounce and lockout.
`timescale 1ns / 1ps

// Each input transaction is one millisecond tick carrying the active-low column
// levels sampled for the row that the previous result asked to drive, and each
// input transaction produces exactly one output transaction: the row drive for
// the coming tick, plus a key report (row times four plus column) on the tick
// where a confirmed key has been released. The block has two register stages:
// an input register that captures col_sense, and an output register holding
// the result. The scan state machine updates between them, so a new
// transaction is accepted every clock cycle while the input is not stalled.
// Input stall is raised only while the input register holds a tick and the
// output register is full and stalled downstream. Configuration
// registers (settle, debounce, release poll, lockout) are written through a
// simple write port and should be changed only while no tick is in flight.
// After reset the block scans rows 0 through 3 continuously, holds the first
// pressed key (first row in scan order, then lowest column), confirms it after
// the debounce gap, waits for all keys up, reports it, and then suppresses new
// detections until lockout_ticks have passed since the scan that found it.

module matrix_keypad_scanner_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Tick input channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [3:0]                      col_sense_i,
  // Result channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [3:0]                      row_drive_o,
  output logic                            key_valid_o,
  output logic [3:0]                      key_index_o,
  // Configuration write port
  input  logic                            cfg_we_i,
  input  logic [kps_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [kps_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import kps_pkg::*;

  cfg_t       cfg;
  result_t    step_res;

  logic       in_vld_q, in_vld_d;
  logic [3:0] col_q, col_d;
  logic       out_vld_q, out_vld_d;
  result_t    res_q, res_d;

  logic       out_hold;
  logic       in_accept;
  logic       step;

  // The output register can take a new result unless it is full and stalled.
  assign out_hold   = out_vld_q && out_stall_i;
  assign step       = in_vld_q && !out_hold;
  assign in_stall_o = in_vld_q && out_hold;
  assign in_accept  = in_valid_i && !in_stall_o;

  kps_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  kps_fsm u_fsm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .col_sense_i (col_q),
    .cfg_i       (cfg),
    .res_o       (step_res)
  );

  // Input register: refilled whenever it is not held by a stalled output.
  always_comb begin
    in_vld_d = in_vld_q;
    col_d    = col_q;
    if (!in_stall_o) begin
      in_vld_d = in_valid_i;
      if (in_accept) begin
        col_d = col_sense_i;
      end
    end
  end

  // Output register: loads the step result, otherwise drains or holds.
  always_comb begin
    out_vld_d = out_vld_q;
    res_d     = res_q;
    if (!out_hold) begin
      out_vld_d = step;
      if (step) begin
        res_d = step_res;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    col_q <= col_d;
    res_q <= res_d;
  end

  assign out_valid_o = out_vld_q;
  assign row_drive_o = res_q.row_drive;
  assign key_valid_o = res_q.key_valid;
  assign key_index_o = res_q.key_index;

  // A key report happens only on a tick with no row driven.
  a_report_idle_rows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && key_valid_o |-> row_drive_o == ROWS_IDLE)
    else $error("key reported while a row is driven");

  // At most one row is ever driven low.
  a_one_row_low : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $countones(~row_drive_o) <= 1)
    else $error("more than one row driven low");

  // The key index is zero on every tick without a report.
  a_index_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !key_valid_o |-> key_index_o == 4'd0)
    else $error("key index nonzero without a report");

  // The input side stalls only when the output is full and held downstream.
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without an output stall");

endmodule

// ----- hdl/kps_cfg.sv -----
// Configuration register file of the keypad scanner.
`timescale 1ns / 1ps

module kps_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [kps_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [kps_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output kps_pkg::cfg_t                    cfg_o
);
  import kps_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_SETTLE:       cfg_d.settle_ticks       = cfg_data_i[3:0];
        CFG_DEBOUNCE:     cfg_d.debounce_ticks     = cfg_data_i[7:0];
        CFG_RELEASE_POLL: cfg_d.release_poll_ticks = cfg_data_i[7:0];
        CFG_LOCKOUT:      cfg_d.lockout_ticks      = cfg_data_i[9:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.settle_ticks       <= SETTLE_RST;
      cfg_q.debounce_ticks     <= DEBOUNCE_RST;
      cfg_q.release_poll_ticks <= RELEASE_POLL_RST;
      cfg_q.lockout_ticks      <= LOCKOUT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- hdl/kps_fsm.sv -----
// Scan, debounce, release and lockout state machine of the keypad scanner.
`timescale 1ns / 1ps

module kps_fsm (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [3:0]        col_sense_i,
  input  kps_pkg::cfg_t     cfg_i,
  output kps_pkg::result_t  res_o
);
  import kps_pkg::*;

  typedef enum logic [2:0] {
    PH_SCAN     = 3'd0,
    PH_DEBOUNCE = 3'd1,
    PH_CONFIRM  = 3'd2,
    PH_RELSCAN  = 3'd3,
    PH_RELWAIT  = 3'd4
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [1:0] row_q, row_d;
  logic [7:0] wait_q, wait_d;
  logic [3:0] held_q, held_d;
  logic [9:0] lock_cnt_q, lock_cnt_d;
  logic       lock_act_q, lock_act_d;

  logic [3:0] pressed;
  logic [9:0] lock_cnt_inc;
  logic [7:0] settle_eff;
  logic [7:0] wait_inc;
  logic [8:0] wait_inc_w;
  logic [1:0] row_nxt;
  logic [1:0] low_col;
  result_t    res;

  // Lowest pressed column; column three when only it (or nothing) is down.
  function automatic logic [1:0] lowest_col(input logic [3:0] p);
    logic [1:0] c;
    if (p[0])      c = 2'd0;
    else if (p[1]) c = 2'd1;
    else if (p[2]) c = 2'd2;
    else           c = 2'd3;
    return c;
  endfunction

  assign pressed      = ~col_sense_i;
  assign lock_cnt_inc = (lock_cnt_q < COUNT_MAX) ? lock_cnt_q + 10'd1 : lock_cnt_q;
  assign settle_eff   = (cfg_i.settle_ticks == 4'd0) ? 8'd1 : {4'd0, cfg_i.settle_ticks};
  assign wait_inc_w   = {1'b0, wait_q} + 9'd1;
  assign wait_inc     = wait_inc_w[7:0];
  assign row_nxt      = row_q + 2'd1;
  assign low_col      = lowest_col(pressed);

  always_comb begin
    phase_d       = phase_q;
    row_d         = row_q;
    wait_d        = wait_q;
    held_d        = held_q;
    lock_cnt_d    = lock_cnt_inc;
    lock_act_d    = lock_act_q;
    res.row_drive = ROWS_IDLE;
    res.key_valid = 1'b0;
    res.key_index = 4'd0;

    case (phase_q)
      PH_SCAN: begin
        if (lock_act_q && (lock_cnt_inc < cfg_i.lockout_ticks)) begin
          row_d  = 2'd0;
          wait_d = 8'd0;
        end else begin
          lock_act_d = 1'b0;
          if (wait_q < settle_eff) begin
            wait_d        = wait_inc;
            res.row_drive = row_pattern(row_q);
          end else if (pressed != 4'd0) begin
            held_d     = {row_q, low_col};
            lock_cnt_d = 10'd0;
            phase_d    = PH_DEBOUNCE;
            wait_d     = 8'd0;
          end else begin
            row_d         = row_nxt;
            wait_d        = 8'd1;
            res.row_drive = row_pattern(row_nxt);
          end
        end
      end
      PH_DEBOUNCE: begin
        wait_d = wait_inc;
        if (wait_inc_w >= {1'b0, cfg_i.debounce_ticks}) begin
          phase_d       = PH_CONFIRM;
          row_d         = held_q[3:2];
          wait_d        = 8'd1;
          res.row_drive = row_pattern(held_q[3:2]);
        end
      end
      PH_CONFIRM: begin
        if (wait_q < settle_eff) begin
          wait_d        = wait_inc;
          res.row_drive = row_pattern(row_q);
        end else begin
          // Confirmed goes on to release scanning, a miss restarts detection.
          phase_d       = pressed[held_q[1:0]] ? PH_RELSCAN : PH_SCAN;
          row_d         = 2'd0;
          wait_d        = 8'd1;
          res.row_drive = row_pattern(2'd0);
        end
      end
      PH_RELSCAN: begin
        if (wait_q < settle_eff) begin
          wait_d        = wait_inc;
          res.row_drive = row_pattern(row_q);
        end else if (pressed != 4'd0) begin
          phase_d = PH_RELWAIT;
          wait_d  = 8'd0;
        end else if (row_q == 2'd3) begin
          res.key_valid = 1'b1;
          res.key_index = held_q;
          lock_act_d    = 1'b1;
          phase_d       = PH_SCAN;
          row_d         = 2'd0;
          wait_d        = 8'd0;
        end else begin
          row_d         = row_nxt;
          wait_d        = 8'd1;
          res.row_drive = row_pattern(row_nxt);
        end
      end
      PH_RELWAIT: begin
        wait_d = wait_inc;
        if (wait_inc_w >= {1'b0, cfg_i.release_poll_ticks}) begin
          phase_d       = PH_RELSCAN;
          row_d         = 2'd0;
          wait_d        = 8'd1;
          res.row_drive = row_pattern(2'd0);
        end
      end
      default: begin
        phase_d = PH_SCAN;
        row_d   = 2'd0;
        wait_d  = 8'd0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_SCAN;
      row_q      <= 2'd0;
      wait_q     <= 8'd0;
      held_q     <= 4'd0;
      lock_cnt_q <= 10'd0;
      lock_act_q <= 1'b0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      row_q      <= row_d;
      wait_q     <= wait_d;
      held_q     <= held_d;
      lock_cnt_q <= lock_cnt_d;
      lock_act_q <= lock_act_d;
    end
  end

  assign res_o = res;

endmodule
